// File: sv/htbd_pkg.sv
package htbd_pkg;

  localparam int IDX_W     = 9;
  localparam int SYM_W     = 8;
  localparam int BYTE_BITS = 8;
  localparam int CNT_W     = $clog2(BYTE_BITS + 1);

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
    logic             leaf;
    logic [SYM_W-1:0] sym;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  // one leaf hit from the walker, and the end-of-byte mark
  typedef struct packed {
    logic             push;
    logic [SYM_W-1:0] sym;
    logic             close;
  } emit_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } walk_state_t;

endpackage

// File: sv/htbd_ram.sv
module htbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/htbd_walk.sv
module htbd_walk import htbd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [IDX_W-1:0]              node_index,
  input  logic [IDX_W-1:0]              left_index,
  input  logic [IDX_W-1:0]              right_index,
  input  logic                          leaf_flag,
  input  logic [SYM_W-1:0]              leaf_symbol,
  input  logic [BYTE_BITS-1:0]          code_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [IDX_W-1:0]              root_node,
  output logic                          ram_we,
  output logic [$clog2(NODE_COUNT)-1:0] ram_waddr,
  output logic [NODE_W-1:0]             ram_wdata,
  output logic [$clog2(NODE_COUNT)-1:0] ram_raddr,
  input  logic [NODE_W-1:0]             ram_rdata,
  output emit_t                         ev,
  input  logic                          can_push
);

  localparam int AW = $clog2(NODE_COUNT);

  walk_state_t          state, state_next;
  logic [IDX_W-1:0]     cur, cur_next;
  logic [IDX_W-1:0]     root;
  logic [BYTE_BITS-1:0] bits;
  logic [CNT_W-1:0]     left_cnt;
  logic                 chk;
  logic                 rd_zero;
  node_t                node;
  logic                 accept;
  logic                 hit;
  logic                 hold;
  logic                 done;
  logic                 step;

  assign accept = in_valid && !in_stall;

  // entries past the table read as an all-zero internal node
  assign node = rd_zero ? '0 : node_t'(ram_rdata);

  assign hit  = (state == ST_WALK) && chk && node.leaf;
  assign hold = hit && !can_push;
  assign done = (state == ST_WALK) && !hold && (left_cnt == '0);
  assign step = (state == ST_WALK) && !hit && (left_cnt != '0);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && opcode == OP_DECODE) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    cfg_ready = (state == ST_IDLE);
    ev.push   = hit && can_push;
    ev.sym    = node.sym;
    ev.close  = done;
  end

  always_comb begin
    cur_next = cur;
    if (state == ST_IDLE && cfg_valid) begin
      cur_next = root_node;
    end else if (hit && can_push) begin
      cur_next = root;
    end else if (step) begin
      cur_next = bits[BYTE_BITS-1] ? node.right : node.left;
    end
  end

  // the read address follows the walk so the next node is ready in the following cycle
  assign ram_raddr = AW'(cur_next);
  assign ram_we    = accept && (opcode == OP_LOAD) && (32'(node_index) < NODE_COUNT);
  assign ram_waddr = AW'(node_index);
  assign ram_wdata = NODE_W'({left_index, right_index, leaf_flag, leaf_symbol});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= '0;
      root     <= '0;
      left_cnt <= '0;
      chk      <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      if (state == ST_IDLE && cfg_valid) begin
        root <= root_node;
      end
      if (accept && opcode == OP_DECODE) begin
        left_cnt <= CNT_W'(BYTE_BITS);
        chk      <= 1'b0;
      end else if (hit && can_push) begin
        chk <= 1'b0;
      end else if (step) begin
        left_cnt <= left_cnt - 1'b1;
        chk      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= !(32'(cur_next) < NODE_COUNT);
    if (accept && opcode == OP_DECODE) begin
      bits <= code_byte;
    end else if (step) begin
      bits <= {bits[BYTE_BITS-2:0], 1'b0};
    end
  end

endmodule

// File: sv/htbd_out.sv
module htbd_out import htbd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  emit_t            ev,
  output logic             can_push,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYM_W-1:0] symbol,
  output logic             last
);

  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_last;
  logic             slot_free;
  logic             move;

  // a pending symbol leaves only once it is known whether it closes its byte
  assign slot_free = !out_valid || !out_stall;
  assign move      = pend_valid && slot_free && (pend_last || ev.push);
  assign can_push  = !pend_valid || slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ev.push) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      symbol <= pend_sym;
      last   <= pend_last;
    end
    if (ev.push) begin
      pend_sym  <= ev.sym;
      pend_last <= ev.close;
    end else if (ev.close) begin
      pend_last <= 1'b1;
    end
  end

endmodule

// File: sv/huffman_tree_bit_decoder_top.sv
// Huffman decoder over a node table held in one RAM. A load item (opcode 0)
// writes one node without an input stall. A decode item (opcode 1) walks
// the tree one code bit per cycle, most significant bit first; it pauses at
// each leaf met before its last code bit, waits at a leaf while the output
// cannot take its symbol, and stalls the input until the byte is done. Each
// leaf gives one symbol transfer, the last one of a byte marked by last;
// the tree position carries over between bytes. A write of root_node also
// restarts the walk at the new root and is taken only while no byte is in
// work. Nodes must be loaded before they are reached; indices at or above
// NODE_COUNT read as an internal node with both children 0.
module huffman_tree_bit_decoder_top import htbd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [IDX_W-1:0]     node_index,
  input  logic [IDX_W-1:0]     left_index,
  input  logic [IDX_W-1:0]     right_index,
  input  logic                 leaf_flag,
  input  logic [SYM_W-1:0]     leaf_symbol,
  input  logic [BYTE_BITS-1:0] code_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SYM_W-1:0]     symbol,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     root_node
);

  localparam int AW = $clog2(NODE_COUNT);

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [NODE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [NODE_W-1:0] ram_rdata;
  emit_t             ev;
  logic              can_push;

  htbd_ram #(
    .WIDTH (NODE_W),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  htbd_walk #(
    .NODE_COUNT (NODE_COUNT)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .node_index  (node_index),
    .left_index  (left_index),
    .right_index (right_index),
    .leaf_flag   (leaf_flag),
    .leaf_symbol (leaf_symbol),
    .code_byte   (code_byte),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .root_node   (root_node),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ev          (ev),
    .can_push    (can_push)
  );

  htbd_out u_out (
    .clk       (clk),
    .rst       (rst),
    .ev        (ev),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last)
  );

endmodule

// File: sv/htbd_chk.sv
module htbd_chk import htbd_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             opcode,
  input logic             out_valid,
  input logic             out_stall,
  input logic [SYM_W-1:0] symbol,
  input logic             last,
  input logic             cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(symbol) && $stable(last))
    else $error("output transfer changed while stalled");

  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready == !in_stall)
    else $error("config ready and input stall disagree");

  a_decode_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_DECODE |=> in_stall)
    else $error("decode transfer did not start a walk");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_LOAD |=> !in_stall)
    else $error("load transfer stalled the input");

endmodule

bind huffman_tree_bit_decoder_top htbd_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .opcode    (opcode),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .symbol    (symbol),
  .last      (last),
  .cfg_ready (cfg_ready)
);

// File: dv/decode_checker.sv
`timescale 1ns / 1ps

module decode_checker import htbd_pkg::*; #(
  parameter int NODE_COUNT = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 opcode,
  input  logic [IDX_W-1:0]     node_index,
  input  logic [IDX_W-1:0]     left_index,
  input  logic [IDX_W-1:0]     right_index,
  input  logic                 leaf_flag,
  input  logic [SYM_W-1:0]     leaf_symbol,
  input  logic [BYTE_BITS-1:0] code_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SYM_W-1:0]     symbol,
  input  logic                 last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [IDX_W-1:0]     root_node,
  output int                   fail_count,
  output int                   pending
);

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             fin;
  } sym_exp_t;

  node_t            tree_mem [NODE_COUNT];
  logic [IDX_W-1:0] walk_root;
  logic [IDX_W-1:0] walk_at;
  sym_exp_t         sym_q[$];
  sym_exp_t         oldest;
  int               fails;

  initial begin
    fails      = 0;
    fail_count = 0;
    pending    = 0;
  end

  // entries beyond the table read back as an all-zero internal node
  function automatic node_t read_node(input logic [IDX_W-1:0] idx);
    if (idx < NODE_COUNT) return tree_mem[idx];
    return '0;
  endfunction

  task automatic walk_byte(input logic [BYTE_BITS-1:0] cb);
    logic [SYM_W-1:0] hits[$];
    node_t            here;
    node_t            nxt;
    sym_exp_t         e;
    int               b;
    int               k;
    for (b = BYTE_BITS - 1; b >= 0; b--) begin
      here    = read_node(walk_at);
      walk_at = cb[b] ? here.right : here.left;
      nxt     = read_node(walk_at);
      if (nxt.leaf) begin
        hits.push_back(nxt.sym);
        walk_at = walk_root;
      end
    end
    for (k = 0; k < hits.size(); k++) begin
      e.sym = hits[k];
      e.fin = (k == hits.size() - 1);
      sym_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      walk_root = '0;
      walk_at   = '0;
      sym_q.delete();
      for (int i = 0; i < NODE_COUNT; i++) tree_mem[i] = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        walk_root = root_node;
        walk_at   = root_node;
      end
      if (in_valid && !in_stall) begin
        if (opcode == OP_LOAD) begin
          if (node_index < NODE_COUNT) begin
            tree_mem[node_index].left  = left_index;
            tree_mem[node_index].right = right_index;
            tree_mem[node_index].leaf  = leaf_flag;
            tree_mem[node_index].sym   = leaf_symbol;
          end
        end else begin
          walk_byte(code_byte);
        end
      end
      if (out_valid && !out_stall) begin
        if (sym_q.size() == 0) begin
          $display("%0t: unexpected symbol transfer, expected none, actual symbol %02h last %0b",
                   $time, symbol, last);
          fails++;
        end else begin
          oldest = sym_q.pop_front();
          if (symbol !== oldest.sym) begin
            $display("%0t: symbol mismatch, expected %02h, actual %02h",
                     $time, oldest.sym, symbol);
            fails++;
          end
          if (last !== oldest.fin) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, oldest.fin, last);
            fails++;
          end
        end
      end
    end
    fail_count <= fails + ((rst === 1'b0) ? 0 : 0);
    pending    <= sym_q.size();
  end

  final_check: assert property (@(posedge clk) 1'b1);

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import htbd_pkg::*;

  localparam int NODE_COUNT  = 512;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 30;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic                 opcode;
  logic [IDX_W-1:0]     node_index;
  logic [IDX_W-1:0]     left_index;
  logic [IDX_W-1:0]     right_index;
  logic                 leaf_flag;
  logic [SYM_W-1:0]     leaf_symbol;
  logic [BYTE_BITS-1:0] code_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [SYM_W-1:0]     symbol;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [IDX_W-1:0]     root_node;

  int               fail_count;
  int               pending;
  int               cycles = 0;
  int               items  = 0;
  bit               fast_mode = 1'b0;
  bit               hold_req  = 1'b0;
  logic [IDX_W-1:0] known_q[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  huffman_tree_bit_decoder_top #(.NODE_COUNT(NODE_COUNT)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .node_index  (node_index),
    .left_index  (left_index),
    .right_index (right_index),
    .leaf_flag   (leaf_flag),
    .leaf_symbol (leaf_symbol),
    .code_byte   (code_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .root_node   (root_node)
  );

  decode_checker #(.NODE_COUNT(NODE_COUNT)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .node_index  (node_index),
    .left_index  (left_index),
    .right_index (right_index),
    .leaf_flag   (leaf_flag),
    .leaf_symbol (leaf_symbol),
    .code_byte   (code_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .root_node   (root_node),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [IDX_W-1:0] pick_known();
    return known_q[$urandom_range(0, known_q.size() - 1)];
  endfunction

  // valid stays high into the next item when no gap is drawn
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                           input logic [IDX_W-1:0] lft, input logic [IDX_W-1:0] rgt,
                           input logic lf, input logic [SYM_W-1:0] sy,
                           input logic [BYTE_BITS-1:0] cb);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode      <= op;
    node_index  <= idx;
    left_index  <= lft;
    right_index <= rgt;
    leaf_flag   <= lf;
    leaf_symbol <= sy;
    code_byte   <= cb;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    items++;
  endtask

  task automatic load_node(input logic [IDX_W-1:0] idx, input logic [IDX_W-1:0] lft,
                           input logic [IDX_W-1:0] rgt, input logic lf,
                           input logic [SYM_W-1:0] sy);
    send_item(OP_LOAD, idx, lft, rgt, lf, sy, BYTE_BITS'($urandom_range(0, 255)));
    known_q.push_back(idx);
  endtask

  task automatic decode_byte(input logic [BYTE_BITS-1:0] cb);
    send_item(OP_DECODE, IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)),
              IDX_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)),
              SYM_W'($urandom_range(0, 255)), cb);
  endtask

  // drain, then allow for a byte still walking without any leaf
  task automatic settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_root(input logic [IDX_W-1:0] idx);
    settle();
    cfg_valid <= 1'b1;
    root_node <= idx;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random full tree: leaves first, then pairs merged under new internal nodes
  task automatic build_tree(output logic [IDX_W-1:0] top_idx);
    logic [IDX_W-1:0] pool[$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] p;
    int               k;
    int               j;
    k = $urandom_range(2, 6);
    repeat (k) begin
      p = IDX_W'($urandom_range(0, 511));
      load_node(p, pick_known(), pick_known(), 1'b1, SYM_W'($urandom_range(0, 255)));
      pool.push_back(p);
    end
    while (pool.size() > 1) begin
      j = $urandom_range(0, pool.size() - 1);
      a = pool[j];
      pool.delete(j);
      j = $urandom_range(0, pool.size() - 1);
      b = pool[j];
      pool.delete(j);
      p = IDX_W'($urandom_range(0, 511));
      load_node(p, a, b, 1'b0, SYM_W'($urandom_range(0, 255)));
      pool.push_back(p);
    end
    top_idx = pool[0];
  endtask

  initial begin
    int n;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = fast_mode ? 0 : $urandom_range(0, 15);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [IDX_W-1:0] r;
    int               phase;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    opcode      <= OP_LOAD;
    node_index  <= '0;
    left_index  <= '0;
    right_index <= '0;
    leaf_flag   <= 1'b0;
    leaf_symbol <= '0;
    code_byte   <= '0;
    out_stall   <= 1'b0;
    cfg_valid   <= 1'b0;
    root_node   <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // small hand-built tree at node 0; node 4 loops back to the root
    load_node(9'd0,   9'd1,   9'd2,   1'b0, 8'h00);
    load_node(9'd1,   9'd511, 9'd0,   1'b1, 8'h00);
    load_node(9'd2,   9'd3,   9'd4,   1'b0, 8'hFF);
    load_node(9'd3,   9'd0,   9'd2,   1'b1, 8'hFF);
    load_node(9'd4,   9'd5,   9'd0,   1'b0, 8'h12);
    load_node(9'd5,   9'd4,   9'd1,   1'b1, 8'hA5);
    load_node(9'd511, 9'd256, 9'd511, 1'b0, 8'h80);
    load_node(9'd256, 9'd511, 9'd3,   1'b1, 8'h7E);
    load_node(9'd6,   9'd1,   9'd3,   1'b1, 8'h3C);
    set_root(9'd0);
    decode_byte(8'h00);
    decode_byte(8'hFF);   // no leaf, walk parks at node 4
    decode_byte(8'h00);   // resumes from node 4
    decode_byte(8'hFF);
    set_root(9'd0);       // root write pulls the walk back
    decode_byte(8'h00);
    decode_byte(8'hAA);
    decode_byte(8'h55);
    set_root(9'd511);
    decode_byte(8'h7F);
    decode_byte(8'hFE);
    set_root(9'd6);       // root itself marked as leaf
    decode_byte(8'h5A);
    decode_byte(8'h00);

    // back-pressure: receiver holds off while bytes keep coming
    build_tree(r);
    set_root(r);
    fast_mode = 1'b1;
    hold_req  = 1'b1;
    repeat (10) decode_byte(BYTE_BITS'($urandom_range(0, 255)));
    settle();

    while (items < 130) begin
      fast_mode = ($urandom_range(0, 3) == 0);
      phase     = $urandom_range(0, 9);
      if (phase < 7) begin
        build_tree(r);
        if ($urandom_range(0, 4) != 0) set_root(r);
        repeat ($urandom_range(3, 10)) decode_byte(BYTE_BITS'($urandom_range(0, 255)));
      end else if (phase < 9) begin
        repeat ($urandom_range(2, 5))
          load_node(IDX_W'($urandom_range(0, 511)), pick_known(), pick_known(),
                    1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
        repeat ($urandom_range(2, 4)) decode_byte(BYTE_BITS'($urandom_range(0, 255)));
      end else begin
        set_root(pick_known());
        repeat ($urandom_range(2, 4)) decode_byte(BYTE_BITS'($urandom_range(0, 255)));
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/htbd_pkg.sv
sv/htbd_ram.sv
sv/htbd_walk.sv
sv/htbd_out.sv
sv/huffman_tree_bit_decoder_top.sv
sv/htbd_chk.sv
dv/decode_checker.sv
dv/tb_top.sv
